### sv/pmas_pkg.sv
package pmas_pkg;

	// Width of every duration figure
	localparam int unsigned VALUE_W = 31;
	// Width of the reported fill count
	localparam int unsigned FILL_OUT_W = 5;
	// Width of the channel field
	localparam int unsigned CHAN_W = 2;

	// Action codes
	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	typedef struct packed {
		logic                action;
		logic [CHAN_W-1:0]   channel;
		logic [VALUE_W-1:0]  sample;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0]    current_value;
		logic [VALUE_W-1:0]    minimum_value;
		logic [VALUE_W-1:0]    maximum_value;
		logic [VALUE_W-1:0]    average_value;
		logic [FILL_OUT_W-1:0] fill_count;
	} rsp_t;

	// Status of the serial divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### sv/per_channel_moving_average_stats_core.sv
// Per-channel running statistics. Each request names a channel; a record
// request stores its sample as the current value, updates minimum and
// maximum (the first sample of a channel sets both), enters it into a ring
// of the last WINDOW samples and recomputes the truncated average of the
// ring. A report request returns the stored figures unchanged; a channel
// at or above CHANNELS returns all zeros. Every request yields one response.
// A report goes straight to the response state. A record passes through the
// update states and a serial divider over the SUM_W-bit sum (SUM_W = 31 +
// clog2(WINDOW), 35 by default), one quotient bit per cycle; once the window
// is full, a state ahead of these reads the oldest sample back from the sample
// RAM. The block takes one request at a time; a finished response waits in
// the output register while the next request is taken.
module per_channel_moving_average_stats_core
	import pmas_pkg::*;
#(
	parameter int unsigned CHANNELS = 4,
	parameter int unsigned WINDOW   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned SL_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned FL_W  = $clog2(WINDOW + 1);
	localparam int unsigned SUM_W = VALUE_W + $clog2(WINDOW);
	localparam int unsigned DEPTH = CHANNELS * WINDOW;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_SUB  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]         state_q;
	logic               act_q;
	logic [CHAN_W-1:0]  ch_q;
	logic [VALUE_W-1:0] smp_q;
	logic               full_q;
	logic [SUM_W-1:0]   acc_q;

	logic [SUM_W-1:0]   sum_q  [CHANNELS];
	logic [FL_W-1:0]    fill_q [CHANNELS];
	logic [SL_W-1:0]    slot_q [CHANNELS];
	logic [VALUE_W-1:0] last_q [CHANNELS];
	logic [VALUE_W-1:0] low_q  [CHANNELS];
	logic [VALUE_W-1:0] high_q [CHANNELS];
	logic [VALUE_W-1:0] mean_q [CHANNELS];

	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [CI_W-1:0]    ci;
	logic [CI_W-1:0]    req_ci;
	logic               ch_ok;
	logic               req_ch_ok;
	logic [SUM_W-1:0]   new_sum;
	logic [FL_W-1:0]    new_fill;
	logic [AW-1:0]      ram_addr;
	logic               ram_en;
	logic               ram_we;
	logic [VALUE_W-1:0] ram_rdata;
	logic               div_start;
	logic [SUM_W-1:0]   div_quo;
	div_stat_t          div_stat;

	assign ci        = CI_W'(ch_q);
	assign req_ci    = CI_W'(req.channel);
	assign ch_ok     = (32'(ch_q) < CHANNELS);
	assign req_ch_ok = (32'(req.channel) < CHANNELS);

	// Ring update: oldest sample already dropped in acc_q, add the new one
	assign new_sum  = acc_q + SUM_W'(smp_q);
	assign new_fill = full_q ? fill_q[ci] : fill_q[ci] + 1'b1;

	// Sample RAM: read the oldest entry, later overwrite the same slot
	assign ram_addr  = AW'(ci) * AW'(WINDOW) + AW'(slot_q[ci]);
	assign ram_en    = (state_q == ST_RD) || (state_q == ST_ADD);
	assign ram_we    = (state_q == ST_ADD);
	assign div_start = (state_q == ST_ADD);

	pmas_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (smp_q),
		.rdata (ram_rdata)
	);

	pmas_div #(
		.NUM_W (SUM_W),
		.DEN_W (FL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_sum),
		.divisor  (new_fill),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer and per-channel statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]  <= '0;
				fill_q[i] <= '0;
				slot_q[i] <= '0;
				last_q[i] <= '0;
				low_q[i]  <= '0;
				high_q[i] <= '0;
				mean_q[i] <= '0;
			end
		end else begin
			// Drop the response once transferred, unless the next one is loaded
			if (rsp_valid_q && rsp_ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (!req_ch_ok || req.action == ACT_REPORT) begin
							state_q <= ST_DONE;
						end else if (fill_q[req_ci] == FL_W'(WINDOW)) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_SUB;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q[ci]  <= new_sum;
					fill_q[ci] <= new_fill;
					last_q[ci] <= smp_q;
					if (fill_q[ci] == '0) begin
						low_q[ci]  <= smp_q;
						high_q[ci] <= smp_q;
					end else begin
						if (smp_q > high_q[ci]) begin
							high_q[ci] <= smp_q;
						end
						if (smp_q < low_q[ci]) begin
							low_q[ci] <= smp_q;
						end
					end
					if (slot_q[ci] == SL_W'(WINDOW - 1)) begin
						slot_q[ci] <= '0;
					end else begin
						slot_q[ci] <= slot_q[ci] + 1'b1;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						mean_q[ci] <= div_quo[VALUE_W-1:0];
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, sum staging and response load
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			act_q  <= req.action;
			ch_q   <= req.channel;
			smp_q  <= req.sample;
			full_q <= req_ch_ok && (fill_q[req_ci] == FL_W'(WINDOW));
		end
		// Hold the sum less the oldest sample when the window is full
		if (state_q == ST_SUB) begin
			acc_q <= sum_q[ci] - (full_q ? SUM_W'(ram_rdata) : '0);
		end
		if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			if (ch_ok) begin
				rsp_q.current_value <= last_q[ci];
				rsp_q.minimum_value <= low_q[ci];
				rsp_q.maximum_value <= high_q[ci];
				rsp_q.average_value <= mean_q[ci];
				rsp_q.fill_count    <= FILL_OUT_W'(fill_q[ci]);
			end else begin
				rsp_q <= '0;
			end
		end
	end

	// A report never reaches the arithmetic states
	a_report_skips_math: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUB || state_q == ST_ADD) |-> act_q == ACT_RECORD && ch_ok)
		else $error("report request entered the update path");

	// Divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider done outside the divide state");

	// Divider is running right after the ring update
	a_add_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |=> state_q == ST_DIV && div_stat.busy)
		else $error("divider not started after update");

	// Until the window fills, the write slot tracks the fill count
	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_ok && fill_q[ci] != FL_W'(WINDOW)) |-> 32'(slot_q[ci]) == 32'(fill_q[ci]))
		else $error("write slot out of step with fill count");

endmodule

### sv/pmas_ram.sv
module pmas_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or read one entry per cycle, read data registered
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/pmas_div.sv
module pmas_div
	import pmas_pkg::*;
#(
	parameter int unsigned NUM_W = 35,
	parameter int unsigned DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output div_stat_t        stat
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_diff;
	logic             ge;

	// Bring down the next dividend bit and try one subtract
	assign rem_sh   = {rem_q, quo_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign ge       = (rem_sh >= {1'b0, den_q});

	// Control: count quotient bits, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = run_q;
	assign stat.done = done_q;

endmodule

### tb/sv/tb.sv
module tb;
	import pmas_pkg::*;

	localparam int unsigned NUM_CHANNELS = 4;
	localparam int unsigned WINDOW_LEN   = 16;
	localparam int unsigned PERIOD       = 12;
	localparam int unsigned PHASE_ITEMS  = 584;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Idle rates in percent for each side
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Running tallies
	int error_count   = 0;
	int record_count  = 0;
	int report_count  = 0;
	int checked_count = 0;

	// Predicted per-channel statistics
	logic [VALUE_W-1:0]    ring_samples [NUM_CHANNELS][WINDOW_LEN];
	logic [34:0]           ring_sum     [NUM_CHANNELS];
	logic [4:0]            ring_fill    [NUM_CHANNELS];
	logic [3:0]            ring_slot    [NUM_CHANNELS];
	logic [VALUE_W-1:0]    latest_value [NUM_CHANNELS];
	logic [VALUE_W-1:0]    low_value    [NUM_CHANNELS];
	logic [VALUE_W-1:0]    high_value   [NUM_CHANNELS];
	logic [VALUE_W-1:0]    mean_of_ring [NUM_CHANNELS];

	// Expected responses in order of request transfer
	rsp_t pending_stats[$];

	per_channel_moving_average_stats_core #(
		.CHANNELS (NUM_CHANNELS),
		.WINDOW   (WINDOW_LEN)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Apply one request to the predicted state and return the expected response
	function automatic rsp_t advance_channel_stats(req_t item);
		rsp_t        expected;
		int unsigned ch;
		logic [3:0]  slot;
		ch       = item.channel;
		expected = '0;
		if (ch >= NUM_CHANNELS)
			return expected;
		if (item.action == ACT_RECORD) begin
			slot = ring_slot[ch];
			// First sample of a channel sets both marks
			if (ring_fill[ch] == 0) begin
				low_value[ch]  = item.sample;
				high_value[ch] = item.sample;
			end else begin
				if (item.sample > high_value[ch])
					high_value[ch] = item.sample;
				if (item.sample < low_value[ch])
					low_value[ch] = item.sample;
			end
			latest_value[ch] = item.sample;
			// Drop the oldest sample once the ring is full
			if (ring_fill[ch] < WINDOW_LEN)
				ring_fill[ch] = ring_fill[ch] + 5'd1;
			else
				ring_sum[ch] = ring_sum[ch] - 35'(ring_samples[ch][slot]);
			ring_samples[ch][slot] = item.sample;
			ring_sum[ch]           = ring_sum[ch] + 35'(item.sample);
			ring_slot[ch]          = (slot == WINDOW_LEN - 1) ? 4'd0 : slot + 4'd1;
			mean_of_ring[ch]       = VALUE_W'(ring_sum[ch] / 35'(ring_fill[ch]));
		end
		expected.current_value = latest_value[ch];
		expected.minimum_value = low_value[ch];
		expected.maximum_value = high_value[ch];
		expected.average_value = mean_of_ring[ch];
		expected.fill_count    = ring_fill[ch];
		return expected;
	endfunction

	function automatic void compare_field(string name, longint unsigned exp_val,
			longint unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val,
				act_val);
			error_count++;
		end
	endfunction

	// Check each response transfer and draw the next ready
	always @(posedge clk) begin
		rsp_t expected;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected response, expected none actual %h", $time, rsp);
				error_count++;
			end else begin
				expected = pending_stats.pop_front();
				compare_field("current_value", expected.current_value, rsp.current_value);
				compare_field("minimum_value", expected.minimum_value, rsp.minimum_value);
				compare_field("maximum_value", expected.maximum_value, rsp.maximum_value);
				compare_field("average_value", expected.average_value, rsp.average_value);
				compare_field("fill_count", expected.fill_count, rsp.fill_count);
				checked_count++;
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Hold valid until the transfer, then record the expectation
	task automatic send_request(logic act, logic [CHAN_W-1:0] ch, logic [VALUE_W-1:0] s);
		req_t item;
		int   gap;
		item.action  = act;
		item.channel = ch;
		item.sample  = s;
		gap          = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pending_stats.push_back(advance_channel_stats(item));
		if (act == ACT_RECORD)
			record_count++;
		else
			report_count++;
	endtask

	// Extremes, untouched channels, first sample and a wrapping window
	task automatic test_directed();
		send_request(ACT_REPORT, 2'd3, '1);
		send_request(ACT_RECORD, 2'd0, 31'h7FFF_FFFF);
		send_request(ACT_RECORD, 2'd0, 31'h0000_0000);
		send_request(ACT_RECORD, 2'd0, 31'h2AAA_AAAA);
		send_request(ACT_REPORT, 2'd0, 31'h7FFF_FFFF);
		send_request(ACT_RECORD, 2'd2, 31'h0000_0000);
		for (int i = 0; i < WINDOW_LEN + 2; i++)
			send_request(ACT_RECORD, 2'd1, (i % 2 == 0) ? 31'h7FFF_FFFF : 31'h5555_5555);
		send_request(ACT_REPORT, 2'd1, 31'h0);
	endtask

	// Mostly records with mixed sample ranges, some reports
	task automatic run_random_items(int count);
		logic               act;
		logic [VALUE_W-1:0] s;
		for (int i = 0; i < count; i++) begin
			act = ($urandom_range(99) < 25) ? ACT_REPORT : ACT_RECORD;
			case ($urandom_range(3))
				0: s = VALUE_W'($urandom);
				1: s = VALUE_W'($urandom_range(255));
				2: s = 31'h7FFF_FFFF - VALUE_W'($urandom_range(255));
				default: s = VALUE_W'($urandom) & VALUE_W'($urandom);
			endcase
			send_request(act, CHAN_W'($urandom_range(NUM_CHANNELS - 1)), s);
		end
	endtask

	task automatic test_slow_receiver();
		send_idle_pct = 18;
		recv_idle_pct = 70;
		run_random_items(PHASE_ITEMS);
	endtask

	task automatic test_slow_sender();
		send_idle_pct = 70;
		recv_idle_pct = 18;
		run_random_items(PHASE_ITEMS);
	endtask

	task automatic test_full_rate();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_items(PHASE_ITEMS);
	endtask

	initial begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			ring_sum[c]     = '0;
			ring_fill[c]    = '0;
			ring_slot[c]    = '0;
			latest_value[c] = '0;
			low_value[c]    = '0;
			high_value[c]   = '0;
			mean_of_ring[c] = '0;
			for (int w = 0; w < WINDOW_LEN; w++)
				ring_samples[c][w] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_slow_receiver();
		test_slow_sender();
		test_full_rate();
		req_valid <= 1'b0;

		// Drain outstanding responses, then let the block settle
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d requests: %0d records and %0d reports over four channels",
			record_count + report_count, record_count, report_count);
		$display("Checked %0d responses under three idle patterns, %0d mismatches",
			checked_count, error_count);
		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(PERIOD * 600000);
		$display("tb: errors");
		$finish;
	end

endmodule

### filelist.f
sv/pmas_pkg.sv
sv/pmas_ram.sv
sv/pmas_div.sv
sv/per_channel_moving_average_stats_core.sv
tb/sv/tb.sv
